>>> rtl/core/ucb_bandit_arm_selector_macros.svh
// Assertion macros shared by the arm selector RTL.
`ifndef UCB_BANDIT_ARM_SELECTOR_MACROS_SVH
`define UCB_BANDIT_ARM_SELECTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define UCB_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UCB_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UCB_ASSERT_IMP(name, clk, rst, ante, cons)
`define UCB_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/ucb_pkg.sv
// Shared types and constants of the UCB arm selector.
package ucb_pkg;

  localparam int ARMS_DEF = 4;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 2'd1;
  localparam logic [15:0] GAIN_RESET = 16'd256;
  localparam logic [15:0] STEP_RESET = 16'd6554;

  localparam logic OP_SELECT   = 1'b0;
  localparam logic OP_FEEDBACK = 1'b1;

  localparam int ARM_OUT_W = 6;
  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam int LNQ_W  = 21;
  localparam int ROOT_W = 19;
  localparam int SQX_W  = 38;
  localparam int BONUS_W = 27;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] LN_ROUNDS = 5'd16;
  localparam logic [CNT_W-1:0] DIV_STEPS = 5'd21;
  localparam logic [CNT_W-1:0] SQ_STEPS  = 5'd19;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEL_INIT, ST_LN_NORM, ST_LN_SQ_MUL, ST_LN_SQ_UPD, ST_LN_FIN,
    ST_ARM_RD, ST_ARM_CHK, ST_DIV, ST_SQ_INIT, ST_SQRT, ST_BONUS, ST_SCORE,
    ST_ARM_NEXT, ST_SEL_DONE, ST_FB_RD, ST_FB_MUL, ST_FB_ADD, ST_FB_DONE
  } state_t;

  typedef struct packed {
    logic cap;
    logic sel_init;
    logic ln_shift;
    logic sq_mul;
    logic sq_upd;
    logic ln_fin;
    logic rd_arm;
    logic rd_last;
    logic set_inf;
    logic div_init;
    logic div_step;
    logic sq_init;
    logic sq_step;
    logic bonus;
    logic score;
    logic ptr_inc;
    logic sel_done;
    logic fb_mul;
    logic fb_wr;
    logic fb_done;
  } cmd_t;

  typedef struct packed {
    logic t_zero;
    logic t_le1;
    logic gain_zero;
    logic m_norm;
    logic cnt_last;
    logic pulls_zero;
    logic best_inf;
    logic ptr_last;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/ucb_if.sv
// Request and result channel interfaces of the UCB arm selector.
interface ucb_req_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [15:0] reward;
  modport source(output valid, output op, output reward, input ready);
  modport sink(input valid, input op, input reward, output ready);
endinterface

interface ucb_rsp_if;
  logic               valid;
  logic               ready;
  logic [5:0]         arm;
  logic signed [31:0] value;
  modport source(output valid, output arm, output value, input ready);
  modport sink(input valid, input arm, input value, output ready);
endinterface

>>> rtl/core/ucb_ctrl.sv
// Controller state machine that sequences the selector datapath.
module ucb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_op,
  output logic          req_ready,
  input  ucb_pkg::sts_t sts,
  output ucb_pkg::cmd_t cmd
);

  ucb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ucb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      ucb_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.cap = 1'b1;
          state_next = (req_op == ucb_pkg::OP_FEEDBACK) ? ucb_pkg::ST_FB_RD
                                                       : ucb_pkg::ST_SEL_INIT;
        end
      end
      ucb_pkg::ST_SEL_INIT: begin
        cmd.sel_init = 1'b1;
        if (sts.t_zero) state_next = ucb_pkg::ST_SEL_DONE;
        else if (sts.t_le1) state_next = ucb_pkg::ST_ARM_RD;
        else state_next = ucb_pkg::ST_LN_NORM;
      end
      ucb_pkg::ST_LN_NORM: begin
        if (sts.m_norm) state_next = ucb_pkg::ST_LN_SQ_MUL;
        else cmd.ln_shift = 1'b1;
      end
      ucb_pkg::ST_LN_SQ_MUL: begin
        cmd.sq_mul = 1'b1;
        state_next = ucb_pkg::ST_LN_SQ_UPD;
      end
      ucb_pkg::ST_LN_SQ_UPD: begin
        cmd.sq_upd = 1'b1;
        state_next = sts.cnt_last ? ucb_pkg::ST_LN_FIN : ucb_pkg::ST_LN_SQ_MUL;
      end
      ucb_pkg::ST_LN_FIN: begin
        cmd.ln_fin = 1'b1;
        state_next = ucb_pkg::ST_ARM_RD;
      end
      ucb_pkg::ST_ARM_RD: begin
        cmd.rd_arm = 1'b1;
        state_next = ucb_pkg::ST_ARM_CHK;
      end
      ucb_pkg::ST_ARM_CHK: begin
        if (sts.pulls_zero) begin
          cmd.set_inf = !sts.t_le1 && !sts.gain_zero && !sts.best_inf;
          state_next = ucb_pkg::ST_ARM_NEXT;
        end else if (sts.best_inf) begin
          state_next = ucb_pkg::ST_ARM_NEXT;
        end else begin
          cmd.div_init = 1'b1;
          state_next = ucb_pkg::ST_DIV;
        end
      end
      ucb_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.cnt_last) state_next = ucb_pkg::ST_SQ_INIT;
      end
      ucb_pkg::ST_SQ_INIT: begin
        cmd.sq_init = 1'b1;
        state_next = ucb_pkg::ST_SQRT;
      end
      ucb_pkg::ST_SQRT: begin
        cmd.sq_step = 1'b1;
        if (sts.cnt_last) state_next = ucb_pkg::ST_BONUS;
      end
      ucb_pkg::ST_BONUS: begin
        cmd.bonus = 1'b1;
        state_next = ucb_pkg::ST_SCORE;
      end
      ucb_pkg::ST_SCORE: begin
        cmd.score = 1'b1;
        state_next = ucb_pkg::ST_ARM_NEXT;
      end
      ucb_pkg::ST_ARM_NEXT: begin
        if (sts.ptr_last) begin
          state_next = ucb_pkg::ST_SEL_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next = ucb_pkg::ST_ARM_RD;
        end
      end
      ucb_pkg::ST_SEL_DONE: begin
        if (sts.out_free) begin
          cmd.sel_done = 1'b1;
          state_next = ucb_pkg::ST_IDLE;
        end
      end
      ucb_pkg::ST_FB_RD: begin
        cmd.rd_last = 1'b1;
        state_next = ucb_pkg::ST_FB_MUL;
      end
      ucb_pkg::ST_FB_MUL: begin
        cmd.fb_mul = 1'b1;
        state_next = ucb_pkg::ST_FB_ADD;
      end
      ucb_pkg::ST_FB_ADD: begin
        cmd.fb_wr = 1'b1;
        state_next = ucb_pkg::ST_FB_DONE;
      end
      ucb_pkg::ST_FB_DONE: begin
        if (sts.out_free) begin
          cmd.fb_done = 1'b1;
          state_next = ucb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ucb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/ucb_dp.sv
// Datapath of the UCB arm selector: arm storage, log, divide, root and update units.
module ucb_dp #(
  parameter int ARMS = ucb_pkg::ARMS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ucb_pkg::cmd_t                    cmd,
  output ucb_pkg::sts_t                    sts,
  input  logic signed [15:0]               req_reward,
  input  logic                             cfg_we,
  input  logic [ucb_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ucb_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             rsp_ready,
  output logic                             rsp_valid,
  output logic [ucb_pkg::ARM_OUT_W-1:0]    rsp_arm,
  output logic signed [31:0]               rsp_value
);

  localparam int ARM_W = $clog2(ARMS);
  localparam int LNQ_W = ucb_pkg::LNQ_W;
  localparam int SQX_W = ucb_pkg::SQX_W;

  // Configuration and persistent state.
  logic [15:0]      gain, step;
  logic [31:0]      t;
  logic [ARM_W-1:0] last_arm;
  logic [ARMS-1:0]  valid;

  logic signed [31:0] est_mem  [ARMS];
  logic [31:0]        pull_mem [ARMS];

  logic signed [31:0] rd_est;
  logic [31:0]        rd_pull;
  logic               rd_vld;

  // Working registers.
  logic [ARM_W-1:0]        ptr, idx;
  logic [31:0]             m;
  logic [4:0]              msb;
  logic [15:0]             frac;
  logic [63:0]             sq_prod;
  logic [ucb_pkg::CNT_W-1:0] cnt;
  logic [LNQ_W-1:0]        lnq, quo;
  logic [31:0]             rem;
  logic [SQX_W-1:0]        sx, sres, sbit;
  logic [ucb_pkg::BONUS_W-1:0] bonus;
  logic signed [33:0]      best;
  logic                    best_inf;
  logic signed [15:0]      reward;
  logic signed [49:0]      fb_prod;
  logic signed [31:0]      ne_reg;
  logic                    res_valid;

  // Combinational helpers.
  logic [ARM_W-1:0]   rd_addr;
  logic signed [31:0] est_eff;
  logic [31:0]        pull_eff;
  logic [32:0]        sq_sh;
  logic [36:0]        ln_prod;
  logic [32:0]        rem_sh;
  logic [SQX_W-1:0]   trial;
  logic [34:0]        bprod;
  logic signed [33:0] score;
  logic signed [32:0] diff;
  logic signed [33:0] delta;
  logic signed [34:0] ne_wide;
  logic signed [31:0] ne;
  logic [31:0]        pull_inc;
  logic               out_free;

  assign rd_addr  = cmd.rd_last ? last_arm : ptr;
  assign est_eff  = rd_vld ? rd_est : 32'sd0;
  assign pull_eff = rd_vld ? rd_pull : 32'd0;
  assign sq_sh    = sq_prod[63:31];
  assign ln_prod  = 37'({msb, frac}) * 37'(ucb_pkg::LN2_Q16);
  assign rem_sh   = {rem, quo[LNQ_W-1]};
  assign trial    = sres + sbit;
  assign bprod    = 35'(gain) * 35'(sres[ucb_pkg::ROOT_W-1:0]);
  assign score    = {{2{est_eff[31]}}, est_eff} + $signed({7'b0, bonus});
  assign diff     = $signed({reward[15], reward, 16'b0}) - $signed({est_eff[31], est_eff});
  assign delta    = fb_prod[49:16];
  assign ne_wide  = $signed({{3{est_eff[31]}}, est_eff}) + $signed({delta[33], delta});
  assign pull_inc = (pull_eff == 32'hFFFF_FFFF) ? pull_eff : pull_eff + 32'd1;
  assign out_free = !res_valid || rsp_ready;

  always_comb begin
    if (ne_wide > 35'sh0_7FFF_FFFF) ne = 32'sh7FFF_FFFF;
    else if (ne_wide < -35'sh0_8000_0000) ne = -32'sh8000_0000;
    else ne = ne_wide[31:0];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain      <= ucb_pkg::GAIN_RESET;
      step      <= ucb_pkg::STEP_RESET;
      t         <= 32'd1;
      last_arm  <= '0;
      valid     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == ucb_pkg::REG_GAIN) gain <= cfg_data;
      if (cfg_we && cfg_idx == ucb_pkg::REG_STEP) step <= cfg_data;
      if (cmd.sel_done) begin
        last_arm <= idx;
        if (t != 32'hFFFF_FFFF) t <= t + 32'd1;
      end
      if (cmd.fb_wr) valid[last_arm] <= 1'b1;
      if (cmd.sel_done || cmd.fb_done) res_valid <= 1'b1;
      else if (rsp_ready) res_valid <= 1'b0;
    end
  end

  // Arm storage, one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd_arm || cmd.rd_last) begin
      rd_est  <= est_mem[rd_addr];
      rd_pull <= pull_mem[rd_addr];
      rd_vld  <= valid[rd_addr];
    end
    if (cmd.fb_wr) begin
      est_mem[last_arm]  <= ne;
      pull_mem[last_arm] <= pull_inc;
    end
  end

  // Arithmetic units.
  always_ff @(posedge clk) begin
    if (cmd.cap) reward <= req_reward;
    if (cmd.sel_init) begin
      m        <= t;
      msb      <= 5'd31;
      frac     <= '0;
      cnt      <= ucb_pkg::LN_ROUNDS;
      lnq      <= '0;
      ptr      <= '0;
      idx      <= '0;
      best     <= '0;
      best_inf <= 1'b0;
    end
    if (cmd.ln_shift) begin
      m   <= {m[30:0], 1'b0};
      msb <= msb - 5'd1;
    end
    if (cmd.sq_mul) sq_prod <= 64'(m) * 64'(m);
    if (cmd.sq_upd) begin
      if (sq_sh[32]) begin
        m    <= sq_sh[32:1];
        frac <= {frac[14:0], 1'b1};
      end else begin
        m    <= sq_sh[31:0];
        frac <= {frac[14:0], 1'b0};
      end
      cnt <= cnt - ucb_pkg::CNT_W'(1);
    end
    if (cmd.ln_fin) lnq <= ln_prod[36:16];
    if (cmd.div_init) begin
      rem <= '0;
      quo <= lnq;
      cnt <= ucb_pkg::DIV_STEPS;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, pull_eff}) begin
        rem <= 32'(rem_sh - {1'b0, pull_eff});
        quo <= {quo[LNQ_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[LNQ_W-2:0], 1'b0};
      end
      cnt <= cnt - ucb_pkg::CNT_W'(1);
    end
    if (cmd.sq_init) begin
      sx   <= {1'b0, quo, 16'b0};
      sres <= '0;
      sbit <= SQX_W'(1) << (SQX_W - 2);
      cnt  <= ucb_pkg::SQ_STEPS;
    end
    if (cmd.sq_step) begin
      if (sx >= trial) begin
        sx   <= sx - trial;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
      sbit <= sbit >> 2;
      cnt  <= cnt - ucb_pkg::CNT_W'(1);
    end
    if (cmd.bonus) bonus <= bprod[34:8];
    if (cmd.score && score > best) begin
      best <= score;
      idx  <= ptr;
    end
    if (cmd.set_inf) begin
      best_inf <= 1'b1;
      idx      <= ptr;
    end
    if (cmd.ptr_inc) ptr <= ptr + ARM_W'(1);
    if (cmd.fb_mul) fb_prod <= 50'($signed({1'b0, step})) * 50'(diff);
    if (cmd.fb_wr) ne_reg <= ne;
    if (cmd.sel_done) begin
      rsp_arm <= ucb_pkg::ARM_OUT_W'(idx);
      if (best_inf || best > 34'sh0_7FFF_FFFF) rsp_value <= 32'sh7FFF_FFFF;
      else rsp_value <= best[31:0];
    end
    if (cmd.fb_done) begin
      rsp_arm   <= ucb_pkg::ARM_OUT_W'(last_arm);
      rsp_value <= ne_reg;
    end
  end

  assign rsp_valid = res_valid;

  assign sts.t_zero     = (t == 32'd0);
  assign sts.t_le1      = (t <= 32'd1);
  assign sts.gain_zero  = (gain == 16'd0);
  assign sts.m_norm     = m[31];
  assign sts.cnt_last   = (cnt == ucb_pkg::CNT_W'(1));
  assign sts.pulls_zero = (pull_eff == 32'd0);
  assign sts.best_inf   = best_inf;
  assign sts.ptr_last   = (ptr == ARM_W'(ARMS - 1));
  assign sts.out_free   = out_free;

endmodule

>>> rtl/core/ucb_bandit_arm_selector.sv
// Top level of the UCB1 bandit arm selector.
// This block keeps a running estimate and a pull count for each of ARMS arms (2 to 64) and
// answers two kinds of request. A select request scores every arm as its estimate plus the
// exploration gain times sqrt(ln t / pulls) in Q16.16, returns the best positive-scoring arm
// (lowest index on ties, arm 0 with value 0 when none qualifies, value 0x7FFFFFFF when an
// untried arm wins) and advances t. A feedback request moves the last chosen arm's estimate
// toward the reward by the step size and counts one pull. Requests are handled one at a
// time by a shared iterative datapath. A select runs the log unit (skipped when t is 1),
// then visits each arm in turn: a skipped or untried arm needs no arithmetic, and a scored
// arm goes through the 21-step divider and the 19-step square root; last the result is
// loaded. A feedback request runs the storage read, one multiply and the write back.
// The result sits in an output register, so the next request is taken while a finished
// result still waits for its consumer.
// Configuration writes (gain at index 0, step size at index 1) must be made while idle.
`include "ucb_bandit_arm_selector_macros.svh"
module ucb_bandit_arm_selector #(
  parameter int ARMS = ucb_pkg::ARMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  ucb_req_if.sink                        req,
  ucb_rsp_if.source                      rsp,
  input  logic                           cfg_we,
  input  logic [ucb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ucb_pkg::CFG_DATA_W-1:0] cfg_data
);

  ucb_pkg::cmd_t cmd;
  ucb_pkg::sts_t sts;
  logic          req_ready;

  ucb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ucb_dp #(.ARMS(ARMS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_reward (req.reward),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .rsp_ready  (rsp.ready),
    .rsp_valid  (rsp.valid),
    .rsp_arm    (rsp.arm),
    .rsp_value  (rsp.value)
  );

  assign req.ready = req_ready;

  // Once a request is taken, the block stays busy for at least the next cycle.
  `UCB_ASSERT_NXT(a_busy_after_req, clk, rst, req.valid && req_ready, !req_ready)
  // A result is only loaded when the output register is free or being emptied.
  `UCB_ASSERT_IMP(a_load_when_free, clk, rst, cmd.sel_done || cmd.fb_done, sts.out_free)
  // The time step starts at one and saturates, so it never reaches zero.
  `UCB_ASSERT_IMP(a_time_nonzero, clk, rst, 1'b1, !sts.t_zero)

endmodule

>>> tb/sv/ucb_bandit_arm_selector_scoreboard.sv
`timescale 1ns / 100ps
// Checker for the UCB arm selector: watches the channels, predicts each result and compares.
module ucb_bandit_arm_selector_scoreboard #(
  parameter int ARMS = ucb_pkg::ARMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_ready,
  input  logic                           req_op,
  input  logic signed [15:0]             req_reward,
  input  logic                           rsp_valid,
  input  logic                           rsp_ready,
  input  logic [5:0]                     rsp_arm,
  input  logic signed [31:0]             rsp_value,
  input  logic                           cfg_we,
  input  logic [ucb_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ucb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             errors,
  output int                             pending
);

  typedef struct {
    logic [5:0]         arm;
    logic signed [31:0] value;
  } choice_t;

  choice_t            awaited_choices[$];
  logic signed [31:0] est_q16 [ARMS];
  logic [31:0]        pull_cnt [ARMS];
  logic [31:0]        t_now;
  logic [5:0]         chosen_arm;
  logic [15:0]        gain_q8;
  logic [15:0]        step_q16;

  task automatic report(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    errors++;
  endtask

  // Natural log in Q16.16 through log2: leading-one position plus 16 squaring rounds.
  function automatic longint unsigned ln_fix(input logic [31:0] t);
    int          msb;
    logic [15:0] frac;
    logic [127:0] m;
    msb = 0;
    frac = '0;
    if (t <= 1) return 0;
    for (int k = 31; k >= 0; k--) begin
      if (t[k]) begin
        msb = k;
        break;
      end
    end
    m = 128'(t) << (31 - msb);
    for (int r = 0; r < 16; r++) begin
      m = (m * m) >> 31;
      frac = {frac[14:0], 1'b0};
      if (m[127:32] != 0) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (((64'(msb) << 16) | 64'(frac)) * 64'(ucb_pkg::LN2_Q16)) >> 16;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic choice_t pick_arm();
    choice_t         c;
    longint unsigned lnq;
    longint unsigned root;
    longint          score;
    longint          best;
    bit              best_inf;
    lnq = ln_fix(t_now);
    best = 0;
    best_inf = 0;
    c.arm = '0;
    for (int i = 0; i < ARMS; i++) begin
      if (t_now == 0) continue;
      if (pull_cnt[i] == 0) begin
        if (t_now <= 1 || gain_q8 == 0) continue;
        if (!best_inf) begin
          best_inf = 1;
          c.arm = 6'(i);
        end
      end else begin
        root = root_floor((lnq / 64'(pull_cnt[i])) << 16);
        score = longint'(est_q16[i]) + longint'((64'(gain_q8) * root) >> 8);
        if (!best_inf && score > best) begin
          best = score;
          c.arm = 6'(i);
        end
      end
    end
    chosen_arm = c.arm;
    if (t_now != 32'hFFFF_FFFF) t_now++;
    if (best_inf || best > 64'sh7FFF_FFFF) c.value = 32'sh7FFF_FFFF;
    else c.value = 32'(best);
    return c;
  endfunction

  function automatic choice_t learn(input logic signed [15:0] reward);
    choice_t c;
    int      a;
    longint  diff;
    longint  ne;
    a = (chosen_arm < ARMS) ? int'(chosen_arm) : 0;
    diff = longint'(reward) * 65536 - longint'(est_q16[a]);
    ne = longint'(est_q16[a]) + ((longint'(step_q16) * diff) >>> 16);
    if (ne > 64'sh7FFF_FFFF) ne = 64'sh7FFF_FFFF;
    if (ne < -64'sh8000_0000) ne = -64'sh8000_0000;
    est_q16[a] = 32'(ne);
    if (pull_cnt[a] != 32'hFFFF_FFFF) pull_cnt[a]++;
    c.arm = 6'(a);
    c.value = est_q16[a];
    return c;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    choice_t got;
    choice_t want;
    if (rst) begin
      for (int i = 0; i < ARMS; i++) begin
        est_q16[i] = '0;
        pull_cnt[i] = '0;
      end
      t_now = 32'd1;
      chosen_arm = '0;
      gain_q8 = ucb_pkg::GAIN_RESET;
      step_q16 = ucb_pkg::STEP_RESET;
      awaited_choices.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_idx == ucb_pkg::REG_GAIN) gain_q8 = cfg_data;
        else if (cfg_idx == ucb_pkg::REG_STEP) step_q16 = cfg_data;
      end
      if (req_valid && req_ready) begin
        if (req_op == ucb_pkg::OP_SELECT) awaited_choices = {awaited_choices, pick_arm()};
        else awaited_choices = {awaited_choices, learn(req_reward)};
      end
      if (rsp_valid && rsp_ready) begin
        got.arm = rsp_arm;
        got.value = rsp_value;
        if (awaited_choices.size() == 0) begin
          report($sformatf("unexpected result arm %0d value %0d", got.arm, got.value));
        end else begin
          want = awaited_choices.pop_front();
          if (got.arm !== want.arm)
            report($sformatf("arm %0d, expected %0d", got.arm, want.arm));
          if (got.value !== want.value)
            report($sformatf("value %0d, expected %0d", got.value, want.value));
        end
      end
    end
    pending = awaited_choices.size();
  end
endmodule

>>> tb/sv/ucb_bandit_arm_selector_tb.sv
`timescale 1ns / 100ps
// Top of the UCB arm selector testbench: clock, reset, stimulus, configuration and verdict.
module ucb_bandit_arm_selector_tb;

  localparam int ARMS = ucb_pkg::ARMS_DEF;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [ucb_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [ucb_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             errors;
  int                             pending;

  // Stall controls for the request driver and the result consumer.
  bit tx_quiet;
  bit rx_quiet;
  bit rx_hold_now;

  ucb_req_if req_ch();
  ucb_rsp_if rsp_ch();

  ucb_bandit_arm_selector #(.ARMS(ARMS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch.sink),
    .rsp     (rsp_ch.source),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  ucb_bandit_arm_selector_scoreboard #(.ARMS(ARMS)) u_scoreboard (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_ch.valid),
    .req_ready (req_ch.ready),
    .req_op    (req_ch.op),
    .req_reward(req_ch.reward),
    .rsp_valid (rsp_ch.valid),
    .rsp_ready (rsp_ch.ready),
    .rsp_arm   (rsp_ch.arm),
    .rsp_value (rsp_ch.value),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop. Roughly 1850 requests with the worst gaps on both sides and the long
  // consumer hold stay well below this bound.
  initial begin
    #50_000_000;
    $display("ucb_bandit_arm_selector_tb: done, errors");
    $finish;
  end

  // Result consumer. It draws a random stall before each result unless the
  // quiet mode is on, and once asked it holds off for a long stretch so that the output
  // register fills and the block stops taking requests.
  initial begin
    bit held_once;
    held_once = 1'b0;
    rsp_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      int gap;
      gap = rx_quiet ? 0 : $urandom_range(0, 19);
      if (rx_hold_now && !held_once) begin
        held_once = 1'b1;
        gap = 3000;
      end
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  // Offers one request and returns at the edge where it was taken. Valid stays high
  // into the next request when no gap is drawn, so it is never dropped and raised in
  // the same step.
  task automatic send_request(input logic op, input logic signed [15:0] reward);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.op     <= op;
    req_ch.reward <= reward;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Lowers valid and waits until every predicted result has been consumed. Every request
  // produces exactly one result, so the block is idle once nothing is pending.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ucb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random reward: mostly full-range values, with the extremes and small values mixed in.
  function automatic logic signed [15:0] draw_reward();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return -16'sh8000;
      2:       return 16'($signed($urandom_range(0, 20)) - 10);
      default: return 16'($urandom);
    endcase
  endfunction

  // A training burst: the usual select then feedback loop with random content, and now
  // and then a lone select or a lone feedback to break the pattern.
  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 9) < 8) begin
        send_request(ucb_pkg::OP_SELECT, 16'($urandom));
        send_request(ucb_pkg::OP_FEEDBACK, draw_reward());
        n++;
      end else begin
        send_request($urandom_range(0, 1) ? ucb_pkg::OP_FEEDBACK : ucb_pkg::OP_SELECT,
                     draw_reward());
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_idx      <= ucb_pkg::REG_GAIN;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.op    <= ucb_pkg::OP_SELECT;
    req_ch.reward <= '0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rx_hold_now = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset settings. Feedback before any select lands on arm 0.
    // The first select at t = 1 skips the untried arms and arm 0 scores below zero, so
    // none qualifies; the next one sees untried arms at t = 2 and the first of them wins
    // with the infinite score.
    send_request(ucb_pkg::OP_FEEDBACK, -16'sh8000);
    send_request(ucb_pkg::OP_SELECT, 16'sh7FFF);
    send_request(ucb_pkg::OP_SELECT, -16'sh8000);
    send_request(ucb_pkg::OP_FEEDBACK, 16'sh7FFF);
    for (int i = 0; i < ARMS; i++) begin
      send_request(ucb_pkg::OP_SELECT, '0);
      send_request(ucb_pkg::OP_FEEDBACK, (i % 2) ? -16'sh8000 : 16'sh7FFF);
    end
    send_request(ucb_pkg::OP_SELECT, '0);
    send_request(ucb_pkg::OP_FEEDBACK, 16'sh0000);
    send_request(ucb_pkg::OP_FEEDBACK, -16'sh0001);
    drain();

    // Zero gain: untried arms become invalid instead of infinite. Full step size drives
    // an estimate nearly all the way to the reward.
    write_reg(ucb_pkg::REG_GAIN, 16'd0);
    write_reg(ucb_pkg::REG_STEP, 16'hFFFF);
    send_request(ucb_pkg::OP_SELECT, '0);
    send_request(ucb_pkg::OP_FEEDBACK, -16'sh8000);
    send_request(ucb_pkg::OP_SELECT, '0);
    send_request(ucb_pkg::OP_FEEDBACK, 16'sh7FFF);
    send_request(ucb_pkg::OP_SELECT, '0);
    run_random(430);
    drain();

    // Largest gain with a full step: high estimates plus the biggest bonus push the
    // winning score past the 32-bit range. The consumer also holds off for a long time
    // here while requests keep coming.
    write_reg(ucb_pkg::REG_GAIN, 16'hFFFF);
    rx_hold_now = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_request(ucb_pkg::OP_SELECT, '0);
      send_request(ucb_pkg::OP_FEEDBACK, 16'sh7FFF);
    end
    run_random(400);
    drain();

    // Zero step size freezes the estimates; the smallest nonzero gain.
    write_reg(ucb_pkg::REG_STEP, 16'd0);
    write_reg(ucb_pkg::REG_GAIN, 16'd1);
    run_random(300);
    drain();

    // Smallest nonzero step, then random settings for the rest of the run.
    write_reg(ucb_pkg::REG_STEP, 16'd1);
    write_reg(ucb_pkg::REG_GAIN, 16'd256);
    run_random(200);
    drain();
    for (int p = 0; p < 3; p++) begin
      write_reg(ucb_pkg::REG_GAIN, 16'($urandom));
      write_reg(ucb_pkg::REG_STEP, 16'($urandom));
      run_random(160);
      drain();
    end

    repeat (300) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ucb_bandit_arm_selector_tb: done, clean");
    end else begin
      $display("ucb_bandit_arm_selector_tb: done, errors");
    end
    $finish;
  end
endmodule
